// ===== design/udp_flood_flow_detector_core_defines.svh =====
// Assertion macros used by the checker file of the UDP flood flow detector.
`ifndef UDP_FLOOD_FLOW_DETECTOR_CORE_DEFINES_SVH
`define UDP_FLOOD_FLOW_DETECTOR_CORE_DEFINES_SVH

// Plain clocked assertion, disabled while reset is asserted.
`define UDPF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication into the following cycle.
`define UDPF_ASSERT_NEXT(label, ante, cons, msg) \
	`UDPF_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== design/udpf_pkg.sv =====
// Package with types, constants and codes of the UDP flood flow detector.
package udpf_pkg;

	// Table sizes and index widths.
	localparam int FLOW_ENTRIES  = 32;
	localparam int BLOCK_ENTRIES = 32;
	localparam int FLOW_IDX_W    = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
	localparam int BLOCK_IDX_W   = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;

	// Header constants.
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  UDP_PROTOCOL   = 8'd17;

	// Configuration port.
	localparam int          APB_ADDR_W     = 4;
	localparam logic [1:0]  REG_THRESHOLD  = 2'd0;
	localparam logic [1:0]  REG_WINDOW     = 2'd1;
	localparam logic [1:0]  REG_MODE       = 2'd2;
	localparam logic [15:0] THRESHOLD_RST  = 16'd30;
	localparam logic [15:0] WINDOW_RST     = 16'd2;

	// Result kinds.
	typedef enum logic [1:0] {
		RK_VERDICT = 2'd0,
		RK_REPORT  = 2'd1,
		RK_TICK    = 2'd2
	} rkind_t;

	// Input operation codes.
	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BSCAN,
		ST_FSCAN,
		ST_WALK,
		ST_BADD,
		ST_TDONE
	} state_t;

	typedef struct packed {
		logic        operation;
		logic [15:0] eth_type;
		logic [7:0]  ip_protocol;
		logic [31:0] source_address;
		logic [15:0] source_port;
		logic [15:0] udp_checksum;
	} in_t;

	typedef struct packed {
		rkind_t      result_kind;
		logic        packet_pass;
		logic [31:0] flow_address;
		logic [15:0] flow_port;
		logic        flow_blocked_now;
		logic        window_closed;
		logic        table_overflow;
		logic        last_result;
	} out_t;

	typedef struct packed {
		logic [15:0] repeat_threshold;
		logic [15:0] window_ticks;
		logic        block_mode;
	} cfg_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] port;
		logic [15:0] csum;
		logic [15:0] cnt;
	} flow_ent_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] port;
	} block_ent_t;

endpackage

// ===== design/udpf_regs.sv =====
// Configuration register file behind the APB-style port.
module udpf_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [udpf_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output udpf_pkg::cfg_t                    cfg
);

	udpf_pkg::cfg_t cfg_q;
	logic [1:0]     reg_idx;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Register writes on the access cycle of a write transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repeat_threshold <= udpf_pkg::THRESHOLD_RST;
			cfg_q.window_ticks     <= udpf_pkg::WINDOW_RST;
			cfg_q.block_mode       <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				udpf_pkg::REG_THRESHOLD: cfg_q.repeat_threshold <= pwdata[15:0];
				udpf_pkg::REG_WINDOW:    cfg_q.window_ticks     <= pwdata[15:0];
				udpf_pkg::REG_MODE:      cfg_q.block_mode       <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read data.
	always_comb begin
		case (reg_idx)
			udpf_pkg::REG_THRESHOLD: prdata = {16'd0, cfg_q.repeat_threshold};
			udpf_pkg::REG_WINDOW:    prdata = {16'd0, cfg_q.window_ticks};
			udpf_pkg::REG_MODE:      prdata = {31'd0, cfg_q.block_mode};
			default:                 prdata = 32'd0;
		endcase
	end

endmodule

// ===== design/udp_flood_flow_detector_core.sv =====
// Top level of the UDP flood flow detector: flow and block tables with their scanning controller.
//
// Channel   Direction  Handshake                      Payload
// command   in         start high while busy low      cmd (udpf_pkg::in_t)
// result    out        result_valid, one cycle        result (udpf_pkg::out_t)
// config    in         APB-style, pready always high  pwdata / prdata
//
// A packet that is not IPv4 UDP gives its verdict in the cycle after the transfer.
// A UDP packet scans the block table, then, if no block entry matches, the flow table, one entry
// per cycle from memories with one write port and one registered read port.
// A tick that does not close the window answers in the next cycle; a closing tick walks the
// flow table, and in block mode scans the block table for each flow at or over the threshold.
// Reset clears the valid flip-flops at once; no clearing pass follows. The receiver
// cannot stall: every result leaves in its cycle.
module udp_flood_flow_detector_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  udpf_pkg::in_t                     cmd,
	output logic                              result_valid,
	output udpf_pkg::out_t                    result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [udpf_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam logic [udpf_pkg::FLOW_IDX_W-1:0] FLOW_LAST =
		udpf_pkg::FLOW_IDX_W'(udpf_pkg::FLOW_ENTRIES - 1);
	localparam logic [udpf_pkg::BLOCK_IDX_W-1:0] BLOCK_LAST =
		udpf_pkg::BLOCK_IDX_W'(udpf_pkg::BLOCK_ENTRIES - 1);

	udpf_pkg::cfg_t cfg;

	// Memories and their registered read data.
	udpf_pkg::flow_ent_t  flow_mem  [udpf_pkg::FLOW_ENTRIES];
	udpf_pkg::block_ent_t block_mem [udpf_pkg::BLOCK_ENTRIES];
	udpf_pkg::flow_ent_t  frd_s1;
	udpf_pkg::block_ent_t brd_s1;
	logic [udpf_pkg::FLOW_IDX_W-1:0]  fidx_s1;
	logic [udpf_pkg::BLOCK_IDX_W-1:0] bidx_s1;
	logic                             rd_s1;

	// Control state.
	udpf_pkg::state_t state_q, state_d;
	logic [udpf_pkg::FLOW_ENTRIES-1:0]  fvalid_q;
	logic [udpf_pkg::BLOCK_ENTRIES-1:0] bvalid_q;
	logic [udpf_pkg::FLOW_IDX_W-1:0]    fscan_q, ffree_q;
	logic [udpf_pkg::BLOCK_IDX_W-1:0]   bscan_q, bfree_q;
	logic                               free_found_q;
	logic                               walk_last_q;
	logic [15:0]                        tick_q, tick_d;

	// Key under search and checksum of the current packet.
	logic [31:0] key_addr_q;
	logic [15:0] key_port_q;
	logic [15:0] csum_q;

	// Combinational controls.
	logic                            acc, is_udp, emit;
	logic                            key_from_cmd, key_from_entry;
	udpf_pkg::out_t                  res_d;
	logic                            f_we, fv_set, fv_clr;
	logic [udpf_pkg::FLOW_IDX_W-1:0] f_wa;
	udpf_pkg::flow_ent_t             f_wd;
	logic                            b_we;
	logic [udpf_pkg::BLOCK_IDX_W-1:0] b_wa;
	logic                            f_hit, b_hit, f_last, b_last;
	logic                            f_free_now, b_free_now;
	logic [udpf_pkg::FLOW_IDX_W-1:0] f_free_idx;
	logic [udpf_pkg::BLOCK_IDX_W-1:0] b_free_idx;
	logic [15:0]                     thr, win, tick_inc;
	logic                            scan_q_st, stay;

	udpf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy = (state_q != udpf_pkg::ST_IDLE);
	assign acc  = start && !busy;

	// Entry compare and free-slot bookkeeping for the entry whose data just arrived.
	assign is_udp     = (cmd.eth_type == udpf_pkg::ETHERTYPE_IPV4) &&
	                    (cmd.ip_protocol == udpf_pkg::UDP_PROTOCOL);
	assign f_hit      = fvalid_q[fidx_s1] && (frd_s1.addr == key_addr_q) &&
	                    (frd_s1.port == key_port_q);
	assign b_hit      = bvalid_q[bidx_s1] && (brd_s1.addr == key_addr_q) &&
	                    (brd_s1.port == key_port_q);
	assign f_last     = (fidx_s1 == FLOW_LAST);
	assign b_last     = (bidx_s1 == BLOCK_LAST);
	assign f_free_now = free_found_q || !fvalid_q[fidx_s1];
	assign b_free_now = free_found_q || !bvalid_q[bidx_s1];
	assign f_free_idx = free_found_q ? ffree_q : fidx_s1;
	assign b_free_idx = free_found_q ? bfree_q : bidx_s1;
	assign thr        = (cfg.repeat_threshold == 16'd0) ? 16'd1 : cfg.repeat_threshold;
	assign win        = (cfg.window_ticks == 16'd0) ? 16'd1 : cfg.window_ticks;
	assign tick_inc   = tick_q + 16'd1;
	assign scan_q_st  = (state_q == udpf_pkg::ST_BSCAN) || (state_q == udpf_pkg::ST_FSCAN) ||
	                    (state_q == udpf_pkg::ST_WALK) || (state_q == udpf_pkg::ST_BADD);
	assign stay       = scan_q_st && (state_d == state_q);

	// Next state, results and table writes.
	always_comb begin
		state_d        = state_q;
		emit           = 1'b0;
		res_d          = '0;
		f_we           = 1'b0;
		f_wa           = fidx_s1;
		f_wd           = frd_s1;
		fv_set         = 1'b0;
		fv_clr         = 1'b0;
		b_we           = 1'b0;
		b_wa           = b_free_idx;
		tick_d         = tick_q;
		key_from_cmd   = 1'b0;
		key_from_entry = 1'b0;
		case (state_q)
			udpf_pkg::ST_IDLE: begin
				if (acc) begin
					if (cmd.operation == udpf_pkg::OP_PACKET) begin
						key_from_cmd = 1'b1;
						if (is_udp) begin
							state_d = udpf_pkg::ST_BSCAN;
						end else begin
							emit                = 1'b1;
							res_d.result_kind   = udpf_pkg::RK_VERDICT;
							res_d.packet_pass   = 1'b1;
							res_d.last_result   = 1'b1;
						end
					end else if (tick_inc >= win) begin
						tick_d  = 16'd0;
						state_d = udpf_pkg::ST_WALK;
					end else begin
						tick_d            = tick_inc;
						emit              = 1'b1;
						res_d.result_kind = udpf_pkg::RK_TICK;
						res_d.last_result = 1'b1;
					end
				end
			end
			udpf_pkg::ST_BSCAN: begin
				if (rd_s1) begin
					if (b_hit) begin
						emit              = 1'b1;
						res_d.result_kind = udpf_pkg::RK_VERDICT;
						res_d.last_result = 1'b1;
						state_d           = udpf_pkg::ST_IDLE;
					end else if (b_last) begin
						state_d = udpf_pkg::ST_FSCAN;
					end
				end
			end
			udpf_pkg::ST_FSCAN: begin
				if (rd_s1) begin
					if (f_hit) begin
						f_we = 1'b1;
						if ((frd_s1.csum == csum_q) && (frd_s1.cnt != 16'hFFFF)) begin
							f_wd.cnt = frd_s1.cnt + 16'd1;
						end
						f_wd.csum = csum_q;
					end else if (f_last && f_free_now) begin
						f_we   = 1'b1;
						fv_set = 1'b1;
						f_wa   = f_free_idx;
						f_wd   = '{addr: key_addr_q, port: key_port_q, csum: csum_q, cnt: 16'd0};
					end
					if (f_hit || f_last) begin
						emit                 = 1'b1;
						res_d.result_kind    = udpf_pkg::RK_VERDICT;
						res_d.packet_pass    = 1'b1;
						res_d.table_overflow = !f_hit && !f_free_now;
						res_d.last_result    = 1'b1;
						state_d              = udpf_pkg::ST_IDLE;
					end
				end
			end
			udpf_pkg::ST_WALK: begin
				if (rd_s1) begin
					fv_clr = 1'b1;
					if (fvalid_q[fidx_s1] && (frd_s1.cnt >= thr)) begin
						if (cfg.block_mode) begin
							key_from_entry = 1'b1;
							state_d        = udpf_pkg::ST_BADD;
						end else begin
							emit               = 1'b1;
							res_d.result_kind  = udpf_pkg::RK_REPORT;
							res_d.flow_address = frd_s1.addr;
							res_d.flow_port    = frd_s1.port;
							if (f_last) begin
								state_d = udpf_pkg::ST_TDONE;
							end
						end
					end else if (f_last) begin
						state_d = udpf_pkg::ST_TDONE;
					end
				end
			end
			udpf_pkg::ST_BADD: begin
				if (rd_s1 && (b_hit || b_last)) begin
					b_we                   = !b_hit && b_free_now;
					emit                   = 1'b1;
					res_d.result_kind      = udpf_pkg::RK_REPORT;
					res_d.flow_address     = key_addr_q;
					res_d.flow_port        = key_port_q;
					res_d.flow_blocked_now = b_hit || b_free_now;
					res_d.table_overflow   = !b_hit && !b_free_now;
					state_d = walk_last_q ? udpf_pkg::ST_TDONE : udpf_pkg::ST_WALK;
				end
			end
			udpf_pkg::ST_TDONE: begin
				emit                = 1'b1;
				res_d.result_kind   = udpf_pkg::RK_TICK;
				res_d.window_closed = 1'b1;
				res_d.last_result   = 1'b1;
				state_d             = udpf_pkg::ST_IDLE;
			end
			default: begin
				state_d = udpf_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= udpf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan counters, read pipeline flag, free-slot tracking, valid bits, tick counter and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fscan_q      <= '0;
			bscan_q      <= '0;
			rd_s1        <= 1'b0;
			free_found_q <= 1'b0;
			tick_q       <= 16'd0;
			fvalid_q     <= '0;
			bvalid_q     <= '0;
			result_valid <= 1'b0;
		end else begin
			rd_s1        <= stay;
			tick_q       <= tick_d;
			result_valid <= emit;
			if (stay && ((state_q == udpf_pkg::ST_BSCAN) || (state_q == udpf_pkg::ST_BADD))) begin
				bscan_q <= (bscan_q == BLOCK_LAST) ? '0 : bscan_q + 1'b1;
			end else begin
				bscan_q <= '0;
			end
			if (stay && ((state_q == udpf_pkg::ST_FSCAN) || (state_q == udpf_pkg::ST_WALK))) begin
				fscan_q <= (fscan_q == FLOW_LAST) ? '0 : fscan_q + 1'b1;
			end else if ((state_q == udpf_pkg::ST_IDLE) ||
			             ((state_d == udpf_pkg::ST_FSCAN) && (state_q != udpf_pkg::ST_FSCAN))) begin
				fscan_q <= '0;
			end
			if (!stay) begin
				free_found_q <= 1'b0;
			end else if (rd_s1 && !free_found_q) begin
				if ((state_q == udpf_pkg::ST_FSCAN) && !fvalid_q[fidx_s1]) begin
					free_found_q <= 1'b1;
				end
				if ((state_q == udpf_pkg::ST_BADD) && !bvalid_q[bidx_s1]) begin
					free_found_q <= 1'b1;
				end
			end
			if (fv_set) begin
				fvalid_q[f_wa] <= 1'b1;
			end
			if (fv_clr) begin
				fvalid_q[fidx_s1] <= 1'b0;
			end
			if (b_we) begin
				bvalid_q[b_wa] <= 1'b1;
			end
		end
	end

	// Payload registers: free-slot indexes, search key, result.
	always_ff @(posedge clk) begin
		if (rd_s1 && !free_found_q) begin
			ffree_q <= fidx_s1;
			bfree_q <= bidx_s1;
		end
		if (key_from_cmd) begin
			key_addr_q <= cmd.source_address;
			key_port_q <= cmd.source_port;
			csum_q     <= cmd.udp_checksum;
		end else if (key_from_entry) begin
			key_addr_q  <= frd_s1.addr;
			key_port_q  <= frd_s1.port;
			walk_last_q <= f_last;
		end
		if (emit) begin
			result <= res_d;
		end
	end

	// Table memories: one write and one registered read per cycle each.
	always_ff @(posedge clk) begin
		frd_s1  <= flow_mem[fscan_q];
		fidx_s1 <= fscan_q;
		if (f_we) begin
			flow_mem[f_wa] <= f_wd;
		end
	end

	always_ff @(posedge clk) begin
		brd_s1  <= block_mem[bscan_q];
		bidx_s1 <= bscan_q;
		if (b_we) begin
			block_mem[b_wa] <= '{addr: key_addr_q, port: key_port_q};
		end
	end

endmodule

// ===== design/udpf_checker.sv =====
// Port-level checker for the UDP flood flow detector and its bind statement.
`include "udp_flood_flow_detector_core_defines.svh"

module udpf_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           result_valid,
	input udpf_pkg::out_t result
);

	// A verdict and a tick-done result always close their command.
	`UDPF_ASSERT(a_verdict_last, result_valid && (result.result_kind == udpf_pkg::RK_VERDICT) |-> result.last_result, "verdict not marked last")
	`UDPF_ASSERT(a_tick_last, result_valid && (result.result_kind == udpf_pkg::RK_TICK) |-> result.last_result, "tick done not marked last")
	// Reports never end a command.
	`UDPF_ASSERT(a_report_not_last, result_valid && (result.result_kind == udpf_pkg::RK_REPORT) |-> !result.last_result, "report marked last")
	// An accepted command either keeps the block busy or answers at once.
	`UDPF_ASSERT_NEXT(a_accept_progress, start && !busy, busy || result_valid, "accepted command dropped")
	// While idle after a final result, no further result appears.
	`UDPF_ASSERT_NEXT(a_no_stray, result_valid && result.last_result && !busy && !start, !result_valid, "result without command")

endmodule

bind udp_flood_flow_detector_core udpf_checker u_udpf_checker (.*);
